// ===== hdl/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  localparam int unsigned STAMP_BYTES = 4;
  localparam int unsigned VALUE_BYTES = 8;

  localparam logic [7:0] START_BYTE_RST = 8'h53;
  localparam logic [7:0] END_BYTE_RST   = 8'h45;

  typedef logic [7:0]         byte_t;
  typedef logic [3:0]         count_t;
  typedef logic [31:0]        stamp_t;
  typedef logic signed [63:0] value_t;

  typedef enum logic {
    CFG_START_BYTE = 1'b0,
    CFG_END_BYTE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_ID    = 3'd2,
    PH_STAMP = 3'd3,
    PH_VALUE = 3'd4,
    PH_CHECK = 3'd5,
    PH_END   = 3'd6
  } phase_e;

endpackage

`default_nettype wire

// ===== hdl/spd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spd_byte_if;
  logic           valid;
  logic           ready;
  spd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_pkt_if;
  logic            valid;
  logic            ready;
  spd_pkg::byte_t  data_type;
  spd_pkg::byte_t  sensor_id;
  spd_pkg::stamp_t time_stamp;
  spd_pkg::value_t sensor_value;
  spd_pkg::byte_t  check_byte;

  modport source (
    output valid, output data_type, output sensor_id, output time_stamp,
    output sensor_value, output check_byte, input ready
  );
  modport sink (
    input valid, input data_type, input sensor_id, input time_stamp,
    input sensor_value, input check_byte, output ready
  );
endinterface

`default_nettype wire

// ===== hdl/sensor_packet_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream packet deframer.
// rx_i carries one received byte per beat; pkt_o carries one decoded packet per beat:
// type, sensor id, 32-bit timestamp and 64-bit signed value (both LSB first on the
// wire) and the nonzero check byte. Zero bytes before the check byte are skipped.
// A packet is emitted only when the byte after the check byte equals end_byte; a
// wrong end byte drops the packet and the block hunts for start_byte again.
// start_byte and end_byte are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// Throughput: one byte per cycle. Each byte updates the framing state in the cycle
// it is accepted; a packet appears on pkt_o in the cycle after its end byte is taken.
// pkt_o is a single output register: while it holds a packet the block keeps taking
// bytes, and stalls rx_i only when a new end byte arrives while pkt_o is still
// blocked by the receiver.
// Reset clears the framing state to hunting, empties pkt_o and restores start_byte
// to 0x53 and end_byte to 0x45.
module sensor_packet_deframer (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire spd_pkg::cfg_idx_e   cfg_idx_i,
  input  wire spd_pkg::byte_t      cfg_data_i,
  spd_byte_if.sink                 rx_i,
  spd_pkt_if.source                pkt_o
);
  import spd_pkg::*;

  byte_t  start_byte_q, end_byte_q;
  phase_e phase_q, phase_d;
  count_t byte_count_q, byte_count_d;
  count_t count_inc;
  stamp_t time_accum_q, time_accum_d;
  value_t value_accum_q, value_accum_d;
  byte_t  held_type_q, held_type_d;
  byte_t  held_id_q, held_id_d;
  byte_t  held_check_q, held_check_d;

  logic   out_valid_q, out_valid_d;
  byte_t  out_type_q, out_id_q, out_check_q;
  stamp_t out_stamp_q;
  value_t out_value_q;

  logic   rx_fire;
  logic   load_pkt;
  byte_t  b;

  assign b         = rx_i.rx_byte;
  assign rx_i.ready = !(phase_q == PH_END && out_valid_q && !pkt_o.ready);
  assign rx_fire   = rx_i.valid && rx_i.ready;
  assign count_inc = byte_count_q + 4'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (rx_fire) begin
      case (phase_q)
        PH_TYPE:  phase_d = PH_ID;
        PH_ID:    phase_d = PH_STAMP;
        PH_STAMP: phase_d = (count_inc >= count_t'(STAMP_BYTES)) ? PH_VALUE : PH_STAMP;
        PH_VALUE: phase_d = (count_inc >= count_t'(VALUE_BYTES)) ? PH_CHECK : PH_VALUE;
        PH_CHECK: phase_d = (b != 8'd0) ? PH_END : PH_CHECK;
        PH_END:   phase_d = PH_HUNT;
        default:  phase_d = (b == start_byte_q) ? PH_TYPE : PH_HUNT;
      endcase
    end
  end

  // datapath and result load
  always_comb begin
    byte_count_d  = byte_count_q;
    time_accum_d  = time_accum_q;
    value_accum_d = value_accum_q;
    held_type_d   = held_type_q;
    held_id_d     = held_id_q;
    held_check_d  = held_check_q;
    load_pkt      = 1'b0;
    if (rx_fire) begin
      case (phase_q)
        PH_TYPE: held_type_d = b;
        PH_ID: begin
          held_id_d    = b;
          byte_count_d = '0;
        end
        PH_STAMP: begin
          time_accum_d[8*byte_count_q[1:0] +: 8] = time_accum_q[8*byte_count_q[1:0] +: 8] | b;
          byte_count_d = (count_inc >= count_t'(STAMP_BYTES)) ? '0 : count_inc;
        end
        PH_VALUE: begin
          value_accum_d[8*byte_count_q[2:0] +: 8] =
            value_accum_q[8*byte_count_q[2:0] +: 8] | b;
          byte_count_d = (count_inc >= count_t'(VALUE_BYTES)) ? '0 : count_inc;
        end
        PH_CHECK: begin
          if (b != 8'd0) begin
            held_check_d = b;
          end
        end
        PH_END: begin
          if (b == end_byte_q) begin
            load_pkt = 1'b1;
          end else begin
            byte_count_d  = '0;
            time_accum_d  = '0;
            value_accum_d = '0;
          end
        end
        default: begin
          if (b == start_byte_q) begin
            byte_count_d  = '0;
            time_accum_d  = '0;
            value_accum_d = '0;
          end
        end
      endcase
    end
    out_valid_d = load_pkt || (out_valid_q && !pkt_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q  <= START_BYTE_RST;
      end_byte_q    <= END_BYTE_RST;
      phase_q       <= PH_HUNT;
      byte_count_q  <= '0;
      time_accum_q  <= '0;
      value_accum_q <= '0;
      held_type_q   <= '0;
      held_id_q     <= '0;
      held_check_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_BYTE: start_byte_q <= cfg_data_i;
          CFG_END_BYTE:   end_byte_q   <= cfg_data_i;
          default:        start_byte_q <= start_byte_q;
        endcase
      end
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      time_accum_q  <= time_accum_d;
      value_accum_q <= value_accum_d;
      held_type_q   <= held_type_d;
      held_id_q     <= held_id_d;
      held_check_q  <= held_check_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pkt) begin
      out_type_q  <= held_type_q;
      out_id_q    <= held_id_q;
      out_stamp_q <= time_accum_q;
      out_value_q <= value_accum_q;
      out_check_q <= held_check_q;
    end
  end

  assign pkt_o.valid        = out_valid_q;
  assign pkt_o.data_type    = out_type_q;
  assign pkt_o.sensor_id    = out_id_q;
  assign pkt_o.time_stamp   = out_stamp_q;
  assign pkt_o.sensor_value = out_value_q;
  assign pkt_o.check_byte   = out_check_q;

  a_end_loads_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && phase_q == PH_END && b == end_byte_q |=> pkt_o.valid)
    else $error("matching end byte did not produce a packet");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_o.valid && !pkt_o.ready && phase_q == PH_END |-> !rx_i.ready)
    else $error("end byte taken while output register blocked");

  a_hunt_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && phase_q == PH_HUNT |=> phase_q == PH_HUNT || phase_q == PH_TYPE)
    else $error("hunt left to an unexpected phase");

  a_stamp_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STAMP |-> byte_count_q < count_t'(STAMP_BYTES))
    else $error("timestamp byte count out of range");

endmodule

`default_nettype wire
